// ----- rtl/ppf_pkg.sv -----
package ppf_pkg;

    // Fixed field widths
    localparam int WORD_W     = 32;
    localparam int RATE_W     = 18;
    localparam int PERIOD_W   = 24;
    localparam int ACC_W      = 32;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Configuration reset values
    localparam logic [RATE_W-1:0]   RATE_RESET   = 18'd48000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd125872;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;

    // Request opcodes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_FETCH = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_TAKEN   = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_DROPPED = 3'd2,
        ST_TICK    = 3'd3,
        ST_WORD    = 3'd4,
        ST_SILENCE = 3'd5,
        ST_NOT_DUE = 3'd6
    } t_status;

    // Commands from the controller to the pacer
    typedef struct packed {
        logic tick;
        logic take;
    } t_pace_cmd;

endpackage

// ----- rtl/ppf_ifs.sv -----
interface ppf_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 opcode;
    logic [ppf_pkg::WORD_W-1:0] push_word;

    modport source (output valid, output opcode, output push_word, input ready);
    modport sink   (input valid, input opcode, input push_word, output ready);
endinterface

interface ppf_rsp_if;
    logic                        valid;
    logic                        ready;
    ppf_pkg::t_status            status;
    logic [ppf_pkg::WORD_W-1:0]  out_word;
    logic                        last;
    logic [ppf_pkg::LEVEL_W-1:0] fill_level;
    logic [ppf_pkg::ACC_W-1:0]   underrun_total;

    modport source (output valid, output status, output out_word, output last,
                    output fill_level, output underrun_total, input ready);
    modport sink   (input valid, input status, input out_word, input last,
                    input fill_level, input underrun_total, output ready);
endinterface

interface ppf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ppf_pkg::CFG_IDX_W-1:0]  index;
    logic [ppf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ppf_store.sv -----
module ppf_store #(
    parameter int DEPTH  = 9216,
    parameter int ADDR_W = 14
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [ADDR_W-1:0]          i_wr_addr,
    input  logic [ppf_pkg::WORD_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ADDR_W-1:0]          i_rd_addr,
    output logic [ppf_pkg::WORD_W-1:0] o_rd_data
);

    logic [ppf_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [ppf_pkg::WORD_W-1:0] r_rd_data;

    // Write one word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one word; hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/ppf_pacer.sv -----
module ppf_pacer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ppf_cfg_if.sink            i_cfg_ch,
    input  ppf_pkg::t_pace_cmd i_cmd,
    output logic               o_due
);

    logic [ppf_pkg::RATE_W-1:0]   r_rate;
    logic [ppf_pkg::PERIOD_W-1:0] r_period;
    logic [ppf_pkg::ACC_W-1:0]    r_acc;
    logic [ppf_pkg::ACC_W-1:0]    period_ext;

    assign i_cfg_ch.ready = 1'b1;
    assign period_ext     = {{(ppf_pkg::ACC_W-ppf_pkg::PERIOD_W){1'b0}}, r_period};
    assign o_due          = (r_acc >= period_ext);

    // Register writes, accumulate on tick, subtract period on a due fetch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= ppf_pkg::RATE_RESET;
            r_period <= ppf_pkg::PERIOD_RESET;
            r_acc    <= '0;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.index)
                ppf_pkg::CFG_RATE: begin
                    r_rate <= i_cfg_ch.data[ppf_pkg::RATE_W-1:0];
                    r_acc  <= '0;
                end
                ppf_pkg::CFG_PERIOD: begin
                    r_period <= i_cfg_ch.data[ppf_pkg::PERIOD_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_cmd.tick) begin
            r_acc <= r_acc + {{(ppf_pkg::ACC_W-ppf_pkg::RATE_W){1'b0}}, r_rate};
        end else if (i_cmd.take) begin
            r_acc <= r_acc - period_ext;
        end
    end

endmodule

// ----- rtl/ppf_ctrl.sv -----
module ppf_ctrl #(
    parameter int RING_DEPTH   = 256,
    parameter int PACKET_WORDS = 36,
    parameter int ADDR_W       = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ppf_req_if.sink                     i_req_ch,
    ppf_rsp_if.source                   o_rsp_ch,
    input  logic                        i_due,
    output ppf_pkg::t_pace_cmd          o_cmd,
    output logic                        o_wr_en,
    output logic [ADDR_W-1:0]           o_wr_addr,
    output logic [ppf_pkg::WORD_W-1:0]  o_wr_data,
    output logic                        o_rd_en,
    output logic [ADDR_W-1:0]           o_rd_addr,
    input  logic [ppf_pkg::WORD_W-1:0]  i_rd_data
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int WIDX_W = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;
    localparam int CNT_W  = $clog2(PACKET_WORDS + 1);
    localparam int LVL_W  = (SLOT_W + 1 > ppf_pkg::LEVEL_W) ? SLOT_W + 1 : ppf_pkg::LEVEL_W;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_STREAM = 2'b10
    } t_state;

    t_state                     r_state, n_state;
    logic                       r_req_valid;
    logic [1:0]                 r_req_op;
    logic [ppf_pkg::WORD_W-1:0] r_req_word;
    logic [SLOT_W-1:0]          r_head, n_head;
    logic [SLOT_W-1:0]          r_tail, n_tail;
    logic [WIDX_W-1:0]          r_widx, n_widx;
    logic [ppf_pkg::ACC_W-1:0]  r_under, n_under;
    logic [ADDR_W-1:0]          r_rd_addr, n_rd_addr;
    logic [CNT_W-1:0]           r_rd_cnt, n_rd_cnt;
    logic                       r_pend, n_pend;
    logic                       r_pend_last, n_pend_last;

    logic                        r_o_valid;
    ppf_pkg::t_status            r_o_status;
    logic [ppf_pkg::WORD_W-1:0]  r_o_word;
    logic                        r_o_last;
    logic [ppf_pkg::LEVEL_W-1:0] r_o_level;
    logic [ppf_pkg::ACC_W-1:0]   r_o_under;

    logic             out_free;
    logic             out_load;
    ppf_pkg::t_status out_status;
    logic [ppf_pkg::WORD_W-1:0] out_word;
    logic             out_last;
    logic             req_done;
    logic [SLOT_W:0]  level;
    logic [LVL_W-1:0] level_ext;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] r;
        if (s == SLOT_W'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] s);
        return ADDR_W'(s) * ADDR_W'(PACKET_WORDS);
    endfunction

    assign out_free       = !r_o_valid || o_rsp_ch.ready;
    assign i_req_ch.ready = !r_req_valid || req_done;

    // Decode the held request and sequence the packet read-out
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_widx      = r_widx;
        n_under     = r_under;
        n_rd_addr   = r_rd_addr;
        n_rd_cnt    = r_rd_cnt;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        o_cmd       = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = slot_base(r_head) + ADDR_W'(r_widx);
        o_wr_data   = r_req_word;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_rd_addr;
        out_load    = 1'b0;
        out_status  = ppf_pkg::ST_TAKEN;
        out_word    = '0;
        out_last    = 1'b1;
        req_done    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (r_req_valid) begin
                    case (r_req_op)
                        ppf_pkg::OP_PUSH: begin
                            if (out_free) begin
                                o_wr_en  = 1'b1;
                                out_load = 1'b1;
                                req_done = 1'b1;
                                if (r_widx == WIDX_W'(PACKET_WORDS - 1)) begin
                                    n_widx = '0;
                                    if (next_slot(r_head) == r_tail) begin
                                        out_status = ppf_pkg::ST_DROPPED;
                                    end else begin
                                        n_head     = next_slot(r_head);
                                        out_status = ppf_pkg::ST_QUEUED;
                                    end
                                end else begin
                                    n_widx     = r_widx + 1'b1;
                                    out_status = ppf_pkg::ST_TAKEN;
                                end
                            end
                        end
                        ppf_pkg::OP_TICK: begin
                            if (out_free) begin
                                o_cmd.tick = 1'b1;
                                out_load   = 1'b1;
                                req_done   = 1'b1;
                                out_status = ppf_pkg::ST_TICK;
                            end
                        end
                        ppf_pkg::OP_FETCH: begin
                            if (!i_due) begin
                                if (out_free) begin
                                    out_load   = 1'b1;
                                    req_done   = 1'b1;
                                    out_status = ppf_pkg::ST_NOT_DUE;
                                end
                            end else if (r_tail == r_head) begin
                                if (out_free) begin
                                    o_cmd.take = 1'b1;
                                    n_under    = r_under + 1'b1;
                                    out_load   = 1'b1;
                                    req_done   = 1'b1;
                                    out_status = ppf_pkg::ST_SILENCE;
                                end
                            end else begin
                                // Dequeue now, stream the slot out next
                                o_cmd.take = 1'b1;
                                n_tail     = next_slot(r_tail);
                                n_rd_addr  = slot_base(r_tail);
                                n_rd_cnt   = '0;
                                n_pend     = 1'b0;
                                n_state    = S_STREAM;
                            end
                        end
                        default: begin
                            // Unused opcode: drop without a result
                            req_done = 1'b1;
                        end
                    endcase
                end
            end
            S_STREAM: begin
                out_status = ppf_pkg::ST_WORD;
                out_word   = i_rd_data;
                out_last   = r_pend_last;
                out_load   = r_pend && out_free;
                o_rd_en    = (r_rd_cnt != CNT_W'(PACKET_WORDS)) && (!r_pend || out_load);
                if (o_rd_en) begin
                    n_rd_addr   = r_rd_addr + 1'b1;
                    n_rd_cnt    = r_rd_cnt + 1'b1;
                    n_pend      = 1'b1;
                    n_pend_last = (r_rd_cnt == CNT_W'(PACKET_WORDS - 1));
                end else if (out_load) begin
                    n_pend = 1'b0;
                end
                if (out_load && r_pend_last) begin
                    req_done = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Ring level after this request's update
    always_comb begin
        if (n_head >= n_tail) begin
            level = {1'b0, n_head} - {1'b0, n_tail};
        end else begin
            level = {1'b0, n_head} + (SLOT_W + 1)'(RING_DEPTH) - {1'b0, n_tail};
        end
        level_ext = LVL_W'(level);
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req_valid <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_widx      <= '0;
            r_under     <= '0;
            r_rd_cnt    <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_widx      <= n_widx;
            r_under     <= n_under;
            r_rd_cnt    <= n_rd_cnt;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            if (i_req_ch.valid && i_req_ch.ready) begin
                r_req_valid <= 1'b1;
            end else if (req_done) begin
                r_req_valid <= 1'b0;
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp_ch.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Capture request and result payloads
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        if (i_req_ch.valid && i_req_ch.ready) begin
            r_req_op   <= i_req_ch.opcode;
            r_req_word <= i_req_ch.push_word;
        end
        if (out_load) begin
            r_o_status <= out_status;
            r_o_word   <= out_word;
            r_o_last   <= out_last;
            r_o_level  <= level_ext[ppf_pkg::LEVEL_W-1:0];
            r_o_under  <= n_under;
        end
    end

    assign o_rsp_ch.valid          = r_o_valid;
    assign o_rsp_ch.status         = r_o_status;
    assign o_rsp_ch.out_word       = r_o_word;
    assign o_rsp_ch.last           = r_o_last;
    assign o_rsp_ch.fill_level     = r_o_level;
    assign o_rsp_ch.underrun_total = r_o_under;

endmodule

// ----- rtl/paced_packet_fifo_top.sv -----
// Push, tick and a fetch that is not due or falls back to silence: one registered
// result each, one request per cycle sustained while the result output is free.
// An unused opcode is dropped in the cycle after it is taken, with no result.
// A due fetch with a queued packet streams PACKET_WORDS words from the packet memory,
// via the read register, one word per cycle unless the output stalls (one read port).
// Synchronous active-low reset empties the ring and resets the pacer and underrun count.
module paced_packet_fifo_top #(
    parameter int RING_DEPTH   = 256,
    parameter int PACKET_WORDS = 36
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppf_req_if.sink   i_req_ch,
    ppf_rsp_if.source o_rsp_ch,
    ppf_cfg_if.sink   i_cfg_ch
);

    localparam int DEPTH  = RING_DEPTH * PACKET_WORDS;
    localparam int ADDR_W = $clog2(DEPTH);

    ppf_pkg::t_pace_cmd         pace_cmd;
    logic                       due;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ppf_pkg::WORD_W-1:0] wr_data;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ppf_pkg::WORD_W-1:0] rd_data;

    ppf_pacer u_pacer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (i_cfg_ch),
        .i_cmd    (pace_cmd),
        .o_due    (due)
    );

    ppf_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ppf_ctrl #(
        .RING_DEPTH   (RING_DEPTH),
        .PACKET_WORDS (PACKET_WORDS),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_ch  (i_req_ch),
        .o_rsp_ch  (o_rsp_ch),
        .i_due     (due),
        .o_cmd     (pace_cmd),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

endmodule

// ----- rtl/ppf_checker.sv -----
module ppf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [2:0]                  i_status,
    input logic [ppf_pkg::WORD_W-1:0]  i_out_word,
    input logic                        i_last,
    input logic [ppf_pkg::LEVEL_W-1:0] i_fill_level,
    input logic [ppf_pkg::ACC_W-1:0]   i_underrun_total
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_out_word) && $stable(i_last) && $stable(i_fill_level)
            && $stable(i_underrun_total))
        else $error("stalled result changed");

    // Only streamed packet words carry data
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ppf_pkg::ST_WORD) |-> (i_out_word == '0))
        else $error("data on a result that is not a packet word");

    // Single-result requests always end their request
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ppf_pkg::ST_WORD) |-> i_last)
        else $error("last missing on a single result");

    // Drop results after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind paced_packet_fifo_top ppf_checker u_ppf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_rsp_ch.valid),
    .i_out_ready      (o_rsp_ch.ready),
    .i_status         (o_rsp_ch.status),
    .i_out_word       (o_rsp_ch.out_word),
    .i_last           (o_rsp_ch.last),
    .i_fill_level     (o_rsp_ch.fill_level),
    .i_underrun_total (o_rsp_ch.underrun_total)
);

// ----- sim/ppf_result_check.sv -----
`timescale 1ns / 100ps

module ppf_result_check #(
    parameter int RING_DEPTH   = 256,
    parameter int PACKET_WORDS = 36
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ppf_req_if   i_req_ch,
    ppf_rsp_if   i_rsp_ch,
    ppf_cfg_if   i_cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);

    import ppf_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_status              status;
        logic [WORD_W-1:0]    out_word;
        logic                 last;
        logic [LEVEL_W-1:0]   fill_level;
        logic [ACC_W-1:0]     underrun_total;
    } t_rsp_item;

    // Expected responses, oldest first
    t_rsp_item expected_q[$];

    // Shadow copy of the ring, pacer and registers
    logic [WORD_W-1:0]   packet_mem [RING_DEPTH*PACKET_WORDS];
    int                  wr_slot;
    int                  rd_slot;
    int                  word_pos;
    logic [ACC_W-1:0]    pace_acc;
    logic [ACC_W-1:0]    silence_count;
    logic [RATE_W-1:0]   rate_reg;
    logic [PERIOD_W-1:0] period_reg;

    int fail_count = 0;
    int reports    = 0;

    // Queue one response, using the state as it stands after the update
    task automatic queue_result(input t_status st, input logic [WORD_W-1:0] w,
                                input logic lst);
        t_rsp_item item;
        item.status         = st;
        item.out_word       = w;
        item.last           = lst;
        item.fill_level     = LEVEL_W'((wr_slot + RING_DEPTH - rd_slot) % RING_DEPTH);
        item.underrun_total = silence_count;
        expected_q.push_back(item);
    endtask

    // Advance the shadow state by one request and queue what it causes
    task automatic predict_request(input logic [1:0] op, input logic [WORD_W-1:0] w);
        int base;
        case (op)
            OP_PUSH: begin
                packet_mem[wr_slot*PACKET_WORDS + word_pos] = w;
                if (word_pos + 1 < PACKET_WORDS) begin
                    word_pos++;
                    queue_result(ST_TAKEN, '0, 1'b1);
                end else begin
                    word_pos = 0;
                    if ((wr_slot + 1) % RING_DEPTH == rd_slot) begin
                        queue_result(ST_DROPPED, '0, 1'b1);
                    end else begin
                        wr_slot = (wr_slot + 1) % RING_DEPTH;
                        queue_result(ST_QUEUED, '0, 1'b1);
                    end
                end
            end
            OP_TICK: begin
                pace_acc = pace_acc + ACC_W'(rate_reg);
                queue_result(ST_TICK, '0, 1'b1);
            end
            OP_FETCH: begin
                if (pace_acc < ACC_W'(period_reg)) begin
                    queue_result(ST_NOT_DUE, '0, 1'b1);
                end else begin
                    pace_acc = pace_acc - ACC_W'(period_reg);
                    if (rd_slot == wr_slot) begin
                        silence_count = silence_count + 1'b1;
                        queue_result(ST_SILENCE, '0, 1'b1);
                    end else begin
                        base    = rd_slot * PACKET_WORDS;
                        rd_slot = (rd_slot + 1) % RING_DEPTH;
                        for (int k = 0; k < PACKET_WORDS; k++) begin
                            queue_result(ST_WORD, packet_mem[base + k],
                                         k == PACKET_WORDS - 1);
                        end
                    end
                end
            end
            default: begin
                // unused opcode: no state change, no response
            end
        endcase
    endtask

    // Compare one accepted response with the oldest expectation
    task automatic check_response();
        t_rsp_item got;
        t_rsp_item want;
        logic      bad;
        got.status         = i_rsp_ch.status;
        got.out_word       = i_rsp_ch.out_word;
        got.last           = i_rsp_ch.last;
        got.fill_level     = i_rsp_ch.fill_level;
        got.underrun_total = i_rsp_ch.underrun_total;
        if (expected_q.size() == 0) begin
            fail_count++;
            if (reports < REPORT_LIMIT) begin
                reports++;
                $display("unexpected response: st=%0d word=%h last=%0d lvl=%0d und=%0d",
                         got.status, got.out_word, got.last, got.fill_level,
                         got.underrun_total);
            end
        end else begin
            want = expected_q.pop_front();
            bad  = (got.status !== want.status) || (got.out_word !== want.out_word) ||
                   (got.last !== want.last) || (got.fill_level !== want.fill_level) ||
                   (got.underrun_total !== want.underrun_total);
            if (bad) begin
                fail_count++;
                if (reports < REPORT_LIMIT) begin
                    reports++;
                    $display("mismatch: exp st=%0d word=%h last=%0d lvl=%0d und=%0d",
                             want.status, want.out_word, want.last, want.fill_level,
                             want.underrun_total);
                    $display("          got st=%0d word=%h last=%0d lvl=%0d und=%0d",
                             got.status, got.out_word, got.last, got.fill_level,
                             got.underrun_total);
                end
            end
        end
    endtask

    // Track every handshake on the three channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_slot       = 0;
            rd_slot       = 0;
            word_pos      = 0;
            pace_acc      = '0;
            silence_count = '0;
            rate_reg      = RATE_RESET;
            period_reg    = PERIOD_RESET;
            expected_q.delete();
        end else begin
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                if (i_cfg_ch.index == CFG_RATE) begin
                    rate_reg = i_cfg_ch.data[RATE_W-1:0];
                    pace_acc = '0;
                end else if (i_cfg_ch.index == CFG_PERIOD) begin
                    period_reg = i_cfg_ch.data[PERIOD_W-1:0];
                end
            end
            if (i_req_ch.valid && i_req_ch.ready) begin
                predict_request(i_req_ch.opcode, i_req_ch.push_word);
            end
            if (i_rsp_ch.valid && i_rsp_ch.ready) begin
                check_response();
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_q.size();
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    import ppf_pkg::*;

    localparam int         RING_DEPTH    = 256;
    localparam int         PACKET_WORDS  = 36;
    localparam int         HOLD_CYCLES   = 600;
    localparam int         SETTLE_CYCLES = 8;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         RATE_MAX      = 192000;
    localparam logic [CFG_DATA_W-1:0] PERIOD_MAX  = 24'hFFFFFF;
    localparam logic [CFG_IDX_W-1:0]  CFG_NONE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0]  CFG_NONE_HI = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppf_req_if req_bus ();
    ppf_rsp_if rsp_bus ();
    ppf_cfg_if cfg_bus ();

    int fail_count;
    int pending_results;

    // No gaps on either side while set, apart from a requested response hold-off
    bit steady = 1'b0;
    int hold_requests = 0;
    int holds_done    = 0;

    paced_packet_fifo_top #(
        .RING_DEPTH   (RING_DEPTH),
        .PACKET_WORDS (PACKET_WORDS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req_ch (req_bus),
        .o_rsp_ch (rsp_bus),
        .i_cfg_ch (cfg_bus)
    );

    ppf_result_check #(
        .RING_DEPTH   (RING_DEPTH),
        .PACKET_WORDS (PACKET_WORDS)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_ch     (req_bus),
        .i_rsp_ch     (rsp_bus),
        .i_cfg_ch     (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #2 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request and hold it until it is taken
    task automatic send_req(input logic [1:0] op, input logic [WORD_W-1:0] w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.opcode    <= op;
        req_bus.push_word <= w;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
    endtask

    // Stop offering, wait for every response, then let the pipeline settle
    task automatic drain();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_packet();
        for (int k = 0; k < PACKET_WORDS; k++) send_req(OP_PUSH, $urandom());
    endtask

    // Mix of whole packets and single requests of every kind
    task automatic random_phase(input int n_items);
        int sent;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            steady = ($urandom_range(0, 3) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 20) begin
                push_packet();
                sent += PACKET_WORDS;
            end else begin
                if (pick < 40)      send_req(OP_PUSH, $urandom());
                else if (pick < 68) send_req(OP_TICK, $urandom());
                else if (pick < 95) send_req(OP_FETCH, $urandom());
                else                send_req(OP_UNUSED, $urandom());
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    // Response side: random stalls, plus a long hold-off on request
    initial begin : rsp_pacing
        int left;
        rsp_bus.ready <= 1'b0;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                rsp_bus.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
                holds_done++;
                left = 0;
            end else if (steady) begin
                rsp_bus.ready <= 1'b1;
                left = 0;
            end else if (left > 0) begin
                left--;
            end else if (rsp_bus.ready) begin
                left = pick_gap();
                if (left > 0) begin
                    rsp_bus.ready <= 1'b0;
                    left--;
                end
            end else begin
                rsp_bus.ready <= 1'b1;
                left = $urandom_range(0, 15);
            end
        end
    end

    initial begin : stimulus
        i_rst_n           <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.opcode    <= OP_PUSH;
        req_bus.push_word <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= CFG_RATE;
        cfg_bus.data      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: not due, unused opcode, silence, partial packet
        send_req(OP_FETCH, 32'h0);
        send_req(OP_UNUSED, 32'hFFFF_FFFF);
        repeat (3) send_req(OP_TICK, 32'h0);
        send_req(OP_FETCH, 32'h0);
        send_req(OP_FETCH, 32'hFFFF_FFFF);
        send_req(OP_PUSH, 32'h0);
        send_req(OP_PUSH, 32'hFFFF_FFFF);
        send_req(OP_PUSH, 32'hA5A5_5A5A);
        send_req(OP_TICK, 32'hFFFF_FFFF);
        drain();

        // Zero period: every fetch is due and nothing is subtracted
        write_reg(CFG_RATE, '0);
        write_reg(CFG_PERIOD, '0);
        send_req(OP_FETCH, 32'h0);
        send_req(OP_TICK, 32'h0);
        send_req(OP_FETCH, 32'h0);
        drain();

        // Undefined indexes must leave the registers alone
        write_reg(CFG_NONE_LO, 24'hFFFFFF);
        write_reg(CFG_NONE_HI, 24'hFFFFFF);

        // Accumulator exactly at the period counts as due
        write_reg(CFG_PERIOD, 24'd3);
        write_reg(CFG_RATE, 24'd1);
        send_req(OP_TICK, 32'h0);
        send_req(OP_TICK, 32'h0);
        send_req(OP_FETCH, 32'h0);
        send_req(OP_TICK, 32'h0);
        send_req(OP_FETCH, 32'h0);
        drain();

        // Queue two packets, stream both out, then fall back to silence
        write_reg(CFG_RATE, 24'(RATE_MAX));
        write_reg(CFG_PERIOD, 24'd1);
        push_packet();
        push_packet();
        send_req(OP_TICK, $urandom());
        for (int p = 0; p < 3; p++) send_req(OP_FETCH, $urandom());
        drain();

        // Random traffic under several pacer settings
        write_reg(CFG_RATE, 24'(RATE_RESET));
        write_reg(CFG_PERIOD, PERIOD_RESET);
        hold_requests++;
        random_phase(50);
        drain();

        write_reg(CFG_RATE, 24'(RATE_MAX));
        write_reg(CFG_PERIOD, 24'd1);
        random_phase(50);
        drain();

        write_reg(CFG_PERIOD, 24'($urandom_range(1, 400000)));
        write_reg(CFG_RATE, 24'($urandom_range(0, RATE_MAX)));
        random_phase(50);
        drain();

        write_reg(CFG_RATE, 24'd1);
        write_reg(CFG_PERIOD, PERIOD_MAX);
        random_phase(40);
        drain();

        if (fail_count == 0 && pending_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin : watchdog
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
